// ----- hw/rtl/line_follow_pd_steering_top_macros.svh -----
// Assertion macros shared by the line follower checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LINE_FOLLOW_PD_STEERING_TOP_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lfs_pkg.sv -----
// Shared types and constants of the line follower steering block.
// No dependencies; imported by every module of the block.
package lfs_pkg;

  // Sensor thresholds and limits.
  localparam logic [11:0] LEVEL_WHITE   = 12'd2500;
  localparam logic [11:0] LEVEL_BLACK   = 12'd1500;
  localparam logic [9:0]  NORM_MAX      = 10'd1000;
  localparam logic [9:0]  STEER_MAX     = 10'd600;
  localparam logic [5:0]  TICK_MAX      = 6'd63;
  localparam logic [5:0]  STARTUP_LIMIT = 6'd50;

  // Division of a 20-bit magnitude by 1000: (mag * DIV_RECIP) >> DIV_SHIFT is exact.
  localparam logic [20:0] DIV_RECIP = 21'd1073742;
  localparam int unsigned DIV_SHIFT = 30;

  // Register reset values.
  localparam logic [7:0]  RST_PROP_GAIN     = 8'd35;
  localparam logic [7:0]  RST_DERIV_GAIN    = 8'd18;
  localparam logic [10:0] RST_FORWARD_SPEED = 11'd1100;
  localparam logic [10:0] RST_TURN_SPEED    = 11'd900;
  localparam logic [9:0]  RST_TURN_STEER    = 10'd450;
  localparam logic [10:0] RST_SEARCH_SPEED  = 11'd700;
  localparam logic [10:0] RST_CLIMB_SPEED   = 11'd1350;
  localparam logic [5:0]  RST_LOST_LIMIT    = 6'd15;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_DERIV_GAIN    = 3'd1,
    REG_FORWARD_SPEED = 3'd2,
    REG_TURN_SPEED    = 3'd3,
    REG_TURN_STEER    = 3'd4,
    REG_SEARCH_SPEED  = 3'd5,
    REG_CLIMB_SPEED   = 3'd6,
    REG_LOST_LIMIT    = 3'd7
  } lfs_reg_e;

  typedef enum logic [2:0] {
    ACT_CLIMB  = 3'd0,
    ACT_TRACK  = 3'd1,
    ACT_SEARCH = 3'd2,
    ACT_TURN   = 3'd3,
    ACT_STOP   = 3'd4
  } lfs_action_e;

  typedef struct packed {
    logic [7:0]  prop_gain;
    logic [7:0]  deriv_gain;
    logic [10:0] forward_speed;
    logic [10:0] turn_speed;
    logic [9:0]  turn_steer;
    logic [10:0] search_speed;
    logic [10:0] climb_speed;
    logic [5:0]  lost_limit;
  } lfs_cfg_t;

  typedef struct packed {
    logic [11:0]        left_level;
    logic [11:0]        right_level;
    logic               middle_white;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
  } lfs_in_t;

  // Stage between the decision logic and the divide-by-1000 step.
  typedef struct packed {
    logic               pd;     // steering still has to be scaled
    logic               neg;    // sign of the PD sum
    logic [19:0]        mag;    // magnitude of the PD sum
    logic [10:0]        speed;
    logic signed [10:0] steer;  // final steering when pd is low
    lfs_action_e        action;
  } lfs_mid_t;

  typedef struct packed {
    logic [10:0]        speed;
    logic signed [10:0] steer;
    lfs_action_e        action;
  } lfs_out_t;

endpackage

// ----- hw/rtl/lfs_cfg.sv -----
// APB register file holding the eight tuning registers.
// Depends on lfs_pkg for the register map and the configuration struct.
module lfs_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output lfs_pkg::lfs_cfg_t cfg_o
);
  import lfs_pkg::*;

  lfs_cfg_t cfg_q, cfg_d;
  lfs_reg_e sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = lfs_reg_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_PROP_GAIN:     cfg_d.prop_gain     = pwdata[7:0];
        REG_DERIV_GAIN:    cfg_d.deriv_gain    = pwdata[7:0];
        REG_FORWARD_SPEED: cfg_d.forward_speed = pwdata[10:0];
        REG_TURN_SPEED:    cfg_d.turn_speed    = pwdata[10:0];
        REG_TURN_STEER:    cfg_d.turn_steer    = pwdata[9:0];
        REG_SEARCH_SPEED:  cfg_d.search_speed  = pwdata[10:0];
        REG_CLIMB_SPEED:   cfg_d.climb_speed   = pwdata[10:0];
        REG_LOST_LIMIT:    cfg_d.lost_limit    = pwdata[5:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PROP_GAIN:     prdata = {24'd0, cfg_q.prop_gain};
      REG_DERIV_GAIN:    prdata = {24'd0, cfg_q.deriv_gain};
      REG_FORWARD_SPEED: prdata = {21'd0, cfg_q.forward_speed};
      REG_TURN_SPEED:    prdata = {21'd0, cfg_q.turn_speed};
      REG_TURN_STEER:    prdata = {22'd0, cfg_q.turn_steer};
      REG_SEARCH_SPEED:  prdata = {21'd0, cfg_q.search_speed};
      REG_CLIMB_SPEED:   prdata = {21'd0, cfg_q.climb_speed};
      REG_LOST_LIMIT:    prdata = {26'd0, cfg_q.lost_limit};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= RST_PROP_GAIN;
      cfg_q.deriv_gain    <= RST_DERIV_GAIN;
      cfg_q.forward_speed <= RST_FORWARD_SPEED;
      cfg_q.turn_speed    <= RST_TURN_SPEED;
      cfg_q.turn_steer    <= RST_TURN_STEER;
      cfg_q.search_speed  <= RST_SEARCH_SPEED;
      cfg_q.climb_speed   <= RST_CLIMB_SPEED;
      cfg_q.lost_limit    <= RST_LOST_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hw/rtl/lfs_track.sv -----
// Decision stage: stall test, white detection, PD products and the tick counters.
// Depends on lfs_pkg; holds the controller state, updated when an item advances.
module lfs_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  lfs_pkg::lfs_in_t  in_i,
  input  lfs_pkg::lfs_cfg_t cfg_i,
  output lfs_pkg::lfs_mid_t mid_o
);
  import lfs_pkg::*;

  typedef enum logic [1:0] {
    SIDE_STRAIGHT = 2'd0,
    SIDE_LEFT     = 2'd1,
    SIDE_RIGHT    = 2'd2
  } side_e;

  logic signed [15:0] prev_lc_q, prev_rc_q;
  logic signed [10:0] prev_err_q, prev_err_d;
  side_e              side_q, side_d, side_pd;
  logic [5:0]         lost_q, lost_d, lost_inc;
  logic [5:0]         search_q, search_d;

  logic signed [16:0] dl, dr;
  logic               still, left_white, right_white, climb, all_white;
  logic [9:0]         ln, rn, tmag;
  logic signed [10:0] err;
  logic signed [11:0] derr;
  logic signed [20:0] p_prod, d_prod, sum, neg_sum;

  function automatic logic [9:0] norm_milli(logic [11:0] lvl);
    logic [11:0] diff;
    diff = LEVEL_WHITE - lvl;
    if (lvl >= LEVEL_WHITE) begin
      return 10'd0;
    end else if (lvl <= LEVEL_BLACK) begin
      return NORM_MAX;
    end else begin
      return diff[9:0];
    end
  endfunction

  always_comb begin
    dl = {in_i.left_count[15], in_i.left_count} - {prev_lc_q[15], prev_lc_q};
    dr = {in_i.right_count[15], in_i.right_count} - {prev_rc_q[15], prev_rc_q};
    still = (dl == 17'sd0 || dl == 17'sd1 || dl == -17'sd1) &&
            (dr == 17'sd0 || dr == 17'sd1 || dr == -17'sd1);
    left_white  = in_i.left_level > LEVEL_WHITE;
    right_white = in_i.right_level > LEVEL_WHITE;
    climb       = !in_i.middle_white && left_white && right_white && still;
    all_white   = in_i.middle_white && left_white && right_white;

    ln   = norm_milli(in_i.left_level);
    rn   = norm_milli(in_i.right_level);
    err  = $signed({1'b0, rn}) - $signed({1'b0, ln});
    derr = {err[10], err} - {prev_err_q[10], prev_err_q};

    p_prod  = $signed({13'd0, cfg_i.prop_gain}) * $signed({{10{err[10]}}, err});
    d_prod  = $signed({13'd0, cfg_i.deriv_gain}) * $signed({{9{derr[11]}}, derr});
    sum     = p_prod + d_prod;
    neg_sum = -sum;

    if (sum > 21'sd0) begin
      side_pd = SIDE_RIGHT;
    end else if (sum < 21'sd0) begin
      side_pd = SIDE_LEFT;
    end else begin
      side_pd = SIDE_STRAIGHT;
    end

    tmag     = (cfg_i.turn_steer > STEER_MAX) ? STEER_MAX : cfg_i.turn_steer;
    lost_inc = (lost_q < TICK_MAX) ? lost_q + 6'd1 : lost_q;

    prev_err_d   = prev_err_q;
    side_d       = side_q;
    lost_d       = lost_q;
    search_d     = search_q;
    mid_o.pd     = 1'b0;
    mid_o.neg    = sum[20];
    mid_o.mag    = sum[20] ? neg_sum[19:0] : sum[19:0];
    mid_o.speed  = cfg_i.search_speed;
    mid_o.steer  = 11'sd0;
    mid_o.action = ACT_SEARCH;

    priority if (climb) begin
      side_d       = SIDE_STRAIGHT;
      lost_d       = 6'd0;
      search_d     = 6'd0;
      prev_err_d   = 11'sd0;
      mid_o.speed  = cfg_i.climb_speed;
      mid_o.action = ACT_CLIMB;
    end else if (all_white) begin
      prev_err_d = 11'sd0;
      if (search_q < STARTUP_LIMIT && side_q == SIDE_STRAIGHT) begin
        // Startup search: drive straight until the line shows up.
        search_d = (search_q < TICK_MAX) ? search_q + 6'd1 : search_q;
        lost_d   = 6'd0;
      end else begin
        lost_d = lost_inc;
        if (lost_inc < cfg_i.lost_limit) begin
          unique case (side_q)
            SIDE_LEFT: begin
              mid_o.speed  = cfg_i.turn_speed;
              mid_o.steer  = -$signed({1'b0, tmag});
              mid_o.action = ACT_TURN;
            end
            SIDE_RIGHT: begin
              mid_o.speed  = cfg_i.turn_speed;
              mid_o.steer  = $signed({1'b0, tmag});
              mid_o.action = ACT_TURN;
            end
            default: begin
              mid_o.speed  = cfg_i.search_speed;
              mid_o.action = ACT_SEARCH;
            end
          endcase
        end else begin
          mid_o.speed  = 11'd0;
          mid_o.action = ACT_STOP;
        end
      end
    end else begin
      prev_err_d   = err;
      side_d       = side_pd;
      lost_d       = 6'd0;
      search_d     = 6'd0;
      mid_o.pd     = 1'b1;
      mid_o.speed  = cfg_i.forward_speed;
      mid_o.action = ACT_TRACK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lc_q  <= 16'sd0;
      prev_rc_q  <= 16'sd0;
      prev_err_q <= 11'sd0;
      side_q     <= SIDE_STRAIGHT;
      lost_q     <= 6'd0;
      search_q   <= 6'd0;
    end else if (fire_i) begin
      prev_lc_q  <= in_i.left_count;
      prev_rc_q  <= in_i.right_count;
      prev_err_q <= prev_err_d;
      side_q     <= side_d;
      lost_q     <= lost_d;
      search_q   <= search_d;
    end
  end

endmodule

// ----- hw/rtl/lfs_scale.sv -----
// Scaling stage: divides the PD sum by 1000 toward zero and clamps to the steer limit.
// Depends on lfs_pkg for the reciprocal constant and the stage structs.
module lfs_scale (
  input  lfs_pkg::lfs_mid_t mid_i,
  output lfs_pkg::lfs_out_t out_o
);
  import lfs_pkg::*;

  logic [40:0] prod;
  logic [10:0] quo;
  logic [9:0]  quo_clamp;

  always_comb begin
    // Reciprocal multiply on the magnitude gives truncation toward zero.
    prod      = {21'd0, mid_i.mag} * {20'd0, DIV_RECIP};
    quo       = prod[DIV_SHIFT +: 11];
    quo_clamp = (quo > {1'b0, STEER_MAX}) ? STEER_MAX : quo[9:0];

    out_o.speed  = mid_i.speed;
    out_o.action = mid_i.action;
    if (mid_i.pd) begin
      out_o.steer = mid_i.neg ? -$signed({1'b0, quo_clamp}) : $signed({1'b0, quo_clamp});
    end else begin
      out_o.steer = mid_i.steer;
    end
  end

endmodule

// ----- hw/rtl/line_follow_pd_steering_top.sv -----
// Top level of the line follower PD steering block: stream ports, APB port, pipeline.
// Depends on lfs_pkg, lfs_cfg, lfs_track and lfs_scale.
//
// Usage:
// Each beat on the slave stream is one control tick: two reflectance levels, the middle
// black/white bit and the two wheel encoder counts. For every accepted beat exactly one
// beat leaves on the master stream with the speed command, the steering command and the
// action code, in the order the ticks came in.
// The item passes three registers: the input register, the decision register (after the
// stall test, mode choice and the two PD gain multipliers) and the output register
// (after the divide by 1000 and the clamp). m_axis_tvalid rises once the item reaches
// the output register, and with the receiver ready and the sender keeping up, one beat
// is taken every cycle.
// The controller state advances as an item leaves the input register, so the next tick
// always sees what the previous tick left behind.
// When the receiver stalls, each stage still takes a new beat as long as it is empty,
// so up to three beats are held before s_axis_tready drops.
// The tuning registers sit on the APB port at byte addresses 0, 4, ... 28; write them
// only while no tick is in flight. Reset clears the pipeline, the tracking state and
// the counters, and loads the default gains and speeds.
module line_follow_pd_steering_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_level[11:0], right_level[23:12], middle_white[24], left_count[40:25],
  // right_count[56:41], zero fill [63:57]
  input  logic [63:0] s_axis_tdata,
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // speed_cmd[10:0], steer_cmd[21:11], action[24:22], zero fill [31:25]
  output logic [31:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lfs_pkg::*;

  lfs_cfg_t cfg;
  lfs_in_t  in_q, in_d;
  lfs_mid_t mid_q, mid_d;
  lfs_out_t out_q, out_d;
  logic     v0_q, v1_q, v2_q;
  logic     rdy0, rdy1, rdy2;
  logic     fire0, fire1, fire2;

  lfs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfs_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire1),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .mid_o  (mid_d)
  );

  lfs_scale u_scale (
    .mid_i (mid_q),
    .out_o (out_d)
  );

  // A stage can load when it is empty or when its content moves on this cycle.
  assign rdy2  = !v2_q || m_axis_tready;
  assign rdy1  = !v1_q || rdy2;
  assign rdy0  = !v0_q || rdy1;
  assign fire0 = s_axis_tvalid && rdy0;
  assign fire1 = v0_q && rdy1;
  assign fire2 = v1_q && rdy2;

  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {7'd0, out_q.action, out_q.steer, out_q.speed};

  always_comb begin
    in_d.left_level   = s_axis_tdata[11:0];
    in_d.right_level  = s_axis_tdata[23:12];
    in_d.middle_white = s_axis_tdata[24];
    in_d.left_count   = s_axis_tdata[40:25];
    in_d.right_count  = s_axis_tdata[56:41];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= fire0 || (v0_q && !rdy1);
      v1_q <= fire1 || (v1_q && !rdy2);
      v2_q <= fire2 || (v2_q && !m_axis_tready);
    end
  end

  // Payload registers carry no reset; the valid bits above qualify them.
  always_ff @(posedge clk_i) begin
    if (fire0) begin
      in_q <= in_d;
    end
    if (fire1) begin
      mid_q <= mid_d;
    end
    if (fire2) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- hw/rtl/lfs_checker.sv -----
// Port-level checker for the line follower steering block, bound to the top level.
// Depends on lfs_pkg and line_follow_pd_steering_top_macros.svh.
`include "line_follow_pd_steering_top_macros.svh"

module lfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import lfs_pkg::*;

  logic signed [10:0] steer;
  logic [2:0]         action;
  logic [10:0]        speed;

  assign speed  = m_axis_tdata[10:0];
  assign steer  = m_axis_tdata[21:11];
  assign action = m_axis_tdata[24:22];

  // Steering never leaves the clamp range.
  `LFS_ASSERT_NOW(a_steer_range, m_axis_tvalid,
    (steer <= 11'sd600) && (steer >= -11'sd600), "steer_cmd out of range")

  // Only tracking and lost-line turns steer; every other mode drives straight.
  `LFS_ASSERT_NOW(a_straight_modes,
    m_axis_tvalid && (action == ACT_CLIMB || action == ACT_SEARCH || action == ACT_STOP),
    steer == 11'sd0, "nonzero steer in a straight mode")

  // A stop result commands zero speed.
  `LFS_ASSERT_NOW(a_stop_speed, m_axis_tvalid && action == ACT_STOP,
    speed == 11'd0, "stop with nonzero speed")

  // Action codes above the stop code never appear.
  `LFS_ASSERT_NOW(a_action_code, m_axis_tvalid,
    action == ACT_CLIMB || action == ACT_TRACK || action == ACT_SEARCH ||
    action == ACT_TURN || action == ACT_STOP, "undefined action code")

  // A stalled result beat stays put.
  `LFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

endmodule

bind line_follow_pd_steering_top lfs_checker u_lfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/line_follow_pd_steering_top_tb.sv -----
// Self-checking testbench for line_follow_pd_steering_top: stream stimulus and APB tuning.
// Depends on lfs_pkg and the line_follow_pd_steering_top RTL; needs no other files.
// A scoreboard class predicts each steering beat and checks the block's results in order.
`timescale 1ns / 1ps

module line_follow_pd_steering_top_tb;
  import lfs_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_TICKS = 80;

  // The last side on which the line was seen, as the controller remembers it.
  typedef enum logic [1:0] {
    SIDE_STRAIGHT = 2'd0,
    SIDE_LEFT     = 2'd1,
    SIDE_RIGHT    = 2'd2
  } side_e;

  // Shapes of tick that the random part strings together.
  typedef enum logic [1:0] {
    TK_TRACK,
    TK_WHITE,
    TK_CLIMB,
    TK_NOISE
  } tick_kind_e;

  // Steering predictor and in-order store of the commands it expects.
  class steering_scoreboard;
    lfs_cfg_t   cfg;
    int         last_lc;
    int         last_rc;
    int         err_hist;
    side_e      side;
    int         lost_n;
    int         search_n;
    lfs_out_t   pending[$];
    int         fail_count;

    function new();
      cfg.prop_gain     = RST_PROP_GAIN;
      cfg.deriv_gain    = RST_DERIV_GAIN;
      cfg.forward_speed = RST_FORWARD_SPEED;
      cfg.turn_speed    = RST_TURN_SPEED;
      cfg.turn_steer    = RST_TURN_STEER;
      cfg.search_speed  = RST_SEARCH_SPEED;
      cfg.climb_speed   = RST_CLIMB_SPEED;
      cfg.lost_limit    = RST_LOST_LIMIT;
      last_lc    = 0;
      last_rc    = 0;
      err_hist   = 0;
      side       = SIDE_STRAIGHT;
      lost_n     = 0;
      search_n   = 0;
      fail_count = 0;
    endfunction

    function logic [31:0] field_of(lfs_cfg_t c, lfs_reg_e r);
      case (r)
        REG_PROP_GAIN:     return 32'(c.prop_gain);
        REG_DERIV_GAIN:    return 32'(c.deriv_gain);
        REG_FORWARD_SPEED: return 32'(c.forward_speed);
        REG_TURN_SPEED:    return 32'(c.turn_speed);
        REG_TURN_STEER:    return 32'(c.turn_steer);
        REG_SEARCH_SPEED:  return 32'(c.search_speed);
        REG_CLIMB_SPEED:   return 32'(c.climb_speed);
        default:           return 32'(c.lost_limit);
      endcase
    endfunction

    function void set_reg(lfs_reg_e r, logic [31:0] v);
      case (r)
        REG_PROP_GAIN:     cfg.prop_gain     = v[7:0];
        REG_DERIV_GAIN:    cfg.deriv_gain    = v[7:0];
        REG_FORWARD_SPEED: cfg.forward_speed = v[10:0];
        REG_TURN_SPEED:    cfg.turn_speed    = v[10:0];
        REG_TURN_STEER:    cfg.turn_steer    = v[9:0];
        REG_SEARCH_SPEED:  cfg.search_speed  = v[10:0];
        REG_CLIMB_SPEED:   cfg.climb_speed   = v[10:0];
        default:           cfg.lost_limit    = v[5:0];
      endcase
    endfunction

    function void flag(string what, int want, int got);
      if (fail_count < 10)
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    endfunction

    // Darkness of one reflectance sample in milli-units: 0 for white, 1000 for black.
    function int level_norm(logic [11:0] lv);
      int n;
      n = int'(LEVEL_WHITE) - int'(lv);
      if (n < 0) n = 0;
      if (n > int'(NORM_MAX)) n = int'(NORM_MAX);
      return n;
    endfunction

    // Called for every accepted input beat; advances the controller state.
    function void note_tick(lfs_in_t t);
      int       lc, rc, dl, dr, e, sum, steer, mag;
      bit       lw, rw, still;
      lfs_out_t res;
      lc = int'($signed(t.left_count));
      rc = int'($signed(t.right_count));
      dl = lc - last_lc;
      dr = rc - last_rc;
      if (dl < 0) dl = -dl;
      if (dr < 0) dr = -dr;
      still   = (dl < 2) && (dr < 2);
      last_lc = lc;
      last_rc = rc;
      lw = t.left_level > LEVEL_WHITE;
      rw = t.right_level > LEVEL_WHITE;
      res.steer = '0;
      if (!t.middle_white && lw && rw && still) begin
        side       = SIDE_STRAIGHT;
        lost_n     = 0;
        search_n   = 0;
        err_hist   = 0;
        res.speed  = cfg.climb_speed;
        res.action = ACT_CLIMB;
      end else if (t.middle_white && lw && rw) begin
        err_hist = 0;
        if (search_n < int'(STARTUP_LIMIT) && side == SIDE_STRAIGHT) begin
          if (search_n < int'(TICK_MAX)) search_n++;
          lost_n     = 0;
          res.speed  = cfg.search_speed;
          res.action = ACT_SEARCH;
        end else begin
          if (lost_n < int'(TICK_MAX)) lost_n++;
          mag = (cfg.turn_steer > STEER_MAX) ? int'(STEER_MAX) : int'(cfg.turn_steer);
          if (lost_n >= int'(cfg.lost_limit)) begin
            res.speed  = '0;
            res.action = ACT_STOP;
          end else if (side == SIDE_LEFT) begin
            res.speed  = cfg.turn_speed;
            res.steer  = 11'(-mag);
            res.action = ACT_TURN;
          end else if (side == SIDE_RIGHT) begin
            res.speed  = cfg.turn_speed;
            res.steer  = 11'(mag);
            res.action = ACT_TURN;
          end else begin
            res.speed  = cfg.search_speed;
            res.action = ACT_SEARCH;
          end
        end
      end else begin
        e     = level_norm(t.right_level) - level_norm(t.left_level);
        sum   = int'(cfg.prop_gain) * e + int'(cfg.deriv_gain) * (e - err_hist);
        steer = sum / 1000;
        if (steer > int'(STEER_MAX)) steer = int'(STEER_MAX);
        if (steer < -int'(STEER_MAX)) steer = -int'(STEER_MAX);
        err_hist   = e;
        side       = (sum > 0) ? SIDE_RIGHT : (sum < 0) ? SIDE_LEFT : SIDE_STRAIGHT;
        lost_n     = 0;
        search_n   = 0;
        res.speed  = cfg.forward_speed;
        res.steer  = 11'(steer);
        res.action = ACT_TRACK;
      end
      pending.push_back(res);
    endfunction

    // Called for every accepted output beat; compares it with the oldest prediction.
    function void check_result(logic [31:0] beat);
      lfs_out_t           want;
      logic [10:0]        spd;
      logic signed [10:0] str;
      logic [2:0]         act;
      spd = beat[10:0];
      str = beat[21:11];
      act = beat[24:22];
      if (pending.size() == 0) begin
        flag("result beat with no tick pending", 0, int'(beat));
        return;
      end
      want = pending.pop_front();
      if (spd != want.speed) flag("speed_cmd", int'(want.speed), int'(spd));
      if (str != want.steer) flag("steer_cmd", int'(want.steer), int'(str));
      if (act != want.action) flag("action", int'(want.action), int'(act));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  steering_scoreboard sb = new();

  // Number of input beats the block has taken so far. The receiver uses it to place its
  // long hold-offs, and both sides use it to find the stretch in which nobody idles.
  int ticks_accepted = 0;

  // Last encoder counts sent, so that random ticks can creep along from there and the
  // stall test sees realistic small differences.
  int enc_l = 0;
  int enc_r = 0;

  line_follow_pd_steering_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Between these beat counts neither side idles, so the pipeline runs at full rate.
  function automatic bit steady_window();
    return (ticks_accepted >= 200) && (ticks_accepted < 300);
  endfunction

  // Offers one tick on the slave stream and returns once it has been taken. The valid
  // stays high after the beat, so back-to-back ticks go out without a bubble; a random
  // gap may drop it first, except inside the steady window.
  task automatic send_tick(lfs_in_t t);
    @(negedge clk_i);
    if (!steady_window()) begin
      while ($urandom_range(0, 99) < 9) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    // right_count, left_count, middle_white, right_level, left_level from the top down.
    s_axis_tdata  <= {7'd0, t.right_count, t.left_count, t.middle_white,
                      t.right_level, t.left_level};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(t);
    ticks_accepted++;
    enc_l = int'($signed(t.left_count));
    enc_r = int'($signed(t.right_count));
  endtask

  function automatic lfs_in_t mk(int left, int right, bit mid, int lc, int rc);
    lfs_in_t t;
    t.left_level   = 12'(left);
    t.right_level  = 12'(right);
    t.middle_white = mid;
    t.left_count   = 16'(lc);
    t.right_count  = 16'(rc);
    return t;
  endfunction

  // One random tick of the given shape. Tracking ticks mostly sit around the black and
  // white thresholds; white and climb ticks keep the wheels nearly still.
  task automatic drive_tick(tick_kind_e kind);
    lfs_in_t t;
    int      step;
    step = (kind == TK_TRACK && $urandom_range(0, 9) == 0) ? 400 : 1;
    t.left_count  = 16'(enc_l + int'($urandom_range(0, 2 * step)) - step);
    t.right_count = 16'(enc_r + int'($urandom_range(0, 2 * step)) - step);
    case (kind)
      TK_TRACK: begin
        t.left_level   = $urandom_range(0, 1) ? 12'($urandom_range(1400, 2600))
                                              : 12'($urandom_range(0, 4095));
        t.right_level  = $urandom_range(0, 1) ? 12'($urandom_range(1400, 2600))
                                              : 12'($urandom_range(0, 4095));
        t.middle_white = 1'($urandom_range(0, 1));
      end
      TK_WHITE, TK_CLIMB: begin
        t.left_level   = 12'($urandom_range(2501, 4095));
        t.right_level  = 12'($urandom_range(2501, 4095));
        t.middle_white = (kind == TK_WHITE);
      end
      default: begin
        t.left_level   = 12'($urandom());
        t.right_level  = 12'($urandom());
        t.middle_white = 1'($urandom());
        t.left_count   = 16'($urandom());
        t.right_count  = 16'($urandom());
      end
    endcase
    send_tick(t);
  endtask

  // Random episodes: short tracking runs, losing the line after tracking, the startup
  // search after a climb tick has cleared the remembered side, climb boosts and noise.
  task automatic run_random(int budget);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, 8);
        repeat (len) drive_tick(TK_TRACK);
      end else if (pick < 55) begin
        // The tracking tick leaves a side behind; the white run then turns and stops,
        // and long runs push the lost counter into saturation.
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 25);
        drive_tick(TK_TRACK);
        repeat (len) drive_tick(TK_WHITE);
        len++;
      end else if (pick < 65) begin
        // Search straight ahead, in most runs run out of startup ticks, then go on with no side known.
        len = $urandom_range(45, 80);
        drive_tick(TK_CLIMB);
        repeat (len) drive_tick(TK_WHITE);
        len++;
      end else if (pick < 85) begin
        len = $urandom_range(1, 4);
        repeat (len) drive_tick(TK_CLIMB);
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) drive_tick(TK_NOISE);
      end
      done += len;
    end
  endtask

  task automatic apb_write(lfs_reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reads every register back and compares it with the predictor's copy.
  task automatic verify_registers();
    lfs_reg_e    r;
    logic [31:0] got;
    r = r.first();
    do begin
      @(negedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {r, 2'b00};
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      got = prdata;
      if (got != sb.field_of(sb.cfg, r)) sb.flag({"readback of ", r.name()},
                                                 int'(sb.field_of(sb.cfg, r)), int'(got));
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      r = r.next();
    end while (r != r.first());
  endtask

  task automatic write_settings(lfs_cfg_t c);
    lfs_reg_e r;
    r = r.first();
    do begin
      apb_write(r, sb.field_of(c, r));
      r = r.next();
    end while (r != r.first());
    verify_registers();
  endtask

  // Drops the valid and waits until every predicted beat has come out through the three
  // pipeline registers, then lets the clock run on before the next phase.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, a steady stretch, and two long hold-offs during
  // which the sender keeps offering ticks until the pipeline is full and stalls.
  initial begin : receiver
    int hold_left;
    int next_hold;
    m_axis_tready = 1'b0;
    hold_left = 0;
    next_hold = 60;
    forever begin
      @(negedge clk_i);
      if (ticks_accepted >= next_hold) begin
        hold_left = 64;
        next_hold = (next_hold == 60) ? 330 : 32'h7fff_ffff;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady_window() || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Output monitor: every accepted result beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    lfs_cfg_t c;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The default gains and speeds must be visible right after reset.
    verify_registers();

    // Directed ticks with the default settings.
    send_tick(mk(4095, 4095, 1'b0, 0, 0));           // climb boost, wheels still
    send_tick(mk(2501, 2501, 1'b0, 1, -1));          // still by a count of one: boost
    send_tick(mk(2501, 4095, 1'b0, 3, -1));          // moved by two: tracking, no error
    send_tick(mk(0, 4095, 1'b1, 32767, -32768));     // full dark left, counts at extremes
    send_tick(mk(4095, 0, 1'b0, -32768, 32767));     // difference beyond 16 bits
    send_tick(mk(1500, 2500, 1'b0, -32768, 32767));  // black and white thresholds
    send_tick(mk(1499, 2501, 1'b1, -32768, 32767));  // just past both thresholds
    send_tick(mk(2500, 2500, 1'b1, -32767, 32766));  // at the white threshold: tracking
    send_tick(mk(2500, 0, 1'b1, -32767, 32766));     // line on the right side
    // Line lost to the left: turn left, all three sensors white.
    send_tick(mk(0, 2400, 1'b0, -32767, 32766));
    send_tick(mk(2501, 2501, 1'b1, -32767, 32766));
    send_tick(mk(4095, 4095, 1'b1, -32767, 32766));
    send_tick(mk(3000, 3000, 1'b1, -32766, 32766));
    // Line lost to the right.
    send_tick(mk(3000, 100, 1'b0, 100, 100));
    send_tick(mk(2600, 2600, 1'b1, 100, 100));
    send_tick(mk(4095, 2501, 1'b1, 101, 99));
    // A climb tick forgets the side; white ticks then search straight ahead.
    send_tick(mk(2600, 2600, 1'b0, 101, 99));
    send_tick(mk(2600, 2600, 1'b1, 500, 99));
    send_tick(mk(4000, 4000, 1'b1, 500, 99));
    // Balanced sensors give a zero PD sum and no side.
    send_tick(mk(1000, 1000, 1'b0, 0, 0));
    send_tick(mk(2600, 2600, 1'b1, 0, 0));
    run_random(PHASE_TICKS);

    // Every register at its top value; the turn magnitude beyond the steering limit.
    drain();
    c.prop_gain     = 8'd255;
    c.deriv_gain    = 8'd255;
    c.forward_speed = 11'd2047;
    c.turn_speed    = 11'd2047;
    c.turn_steer    = 10'd1023;
    c.search_speed  = 11'd2047;
    c.climb_speed   = 11'd2047;
    c.lost_limit    = 6'd63;
    write_settings(c);
    run_random(PHASE_TICKS);

    // Every register at zero: no steering, and a zero lost limit stops at once.
    drain();
    c = '0;
    write_settings(c);
    run_random(PHASE_TICKS);

    // Random settings.
    drain();
    c.prop_gain     = 8'($urandom());
    c.deriv_gain    = 8'($urandom());
    c.forward_speed = 11'($urandom());
    c.turn_speed    = 11'($urandom());
    c.turn_steer    = 10'($urandom());
    c.search_speed  = 11'($urandom());
    c.climb_speed   = 11'($urandom());
    c.lost_limit    = 6'($urandom_range(1, 63));
    write_settings(c);
    run_random(PHASE_TICKS);

    // Turn magnitude right at the limit and a lost limit of one, which stops on the first lost tick.
    drain();
    c.prop_gain     = 8'($urandom_range(100, 255));
    c.deriv_gain    = 8'($urandom());
    c.turn_steer    = STEER_MAX;
    c.lost_limit    = 6'd1;
    write_settings(c);
    run_random(PHASE_TICKS);

    drain();
    if (sb.fail_count == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
